// ===== design/pspt_pkg.sv =====
// ---------------------------------------------------------------------------
// pspt_pkg: shared types and constants of the pseudosquare primality tester
// Holds the sequencer states, verdict codes, the pseudosquare bound table and
// the small prime bases used by the Euler tests.
// ---------------------------------------------------------------------------
package pspt_pkg;

  localparam int WORD_W  = 64;   // candidate width
  localparam int PRIME_W = 16;   // width of any trial prime (up to 65535)
  localparam int IDX_W   = 6;    // index into the pseudosquare and base tables
  localparam int PSQ_N   = 52;   // pseudosquares held in the table
  localparam int BASE_N  = 53;   // Euler test bases held in the table

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_UNPROVEN  = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    S_BOOT_CAND,
    S_BOOT_DIV,
    S_IDLE,
    S_TRIAL,
    S_TRIAL_DIV,
    S_BOUND,
    S_SCAN,
    S_EXP_START,
    S_POW,
    S_MACC,
    S_MSQ,
    S_EXP_CHECK,
    S_DONE
  } state_t;

  // Pseudosquares: smallest non-square numbers that are quadratic residues
  // of all primes up to a given bound.
  localparam logic [WORD_W-1:0] PSQ_TAB [PSQ_N] = '{
    64'd17, 64'd73, 64'd241, 64'd1009, 64'd2641, 64'd8089, 64'd18001,
    64'd53881, 64'd87481, 64'd117049, 64'd515761, 64'd1083289, 64'd3206641,
    64'd3818929, 64'd9257329, 64'd22000801, 64'd48473881, 64'd48473881,
    64'd175244281, 64'd427733329, 64'd427733329, 64'd898716289,
    64'd2805544681, 64'd2805544681, 64'd2805544681, 64'd10310263441,
    64'd23616331489, 64'd85157610409, 64'd85157610409, 64'd196265095009,
    64'd196265095009, 64'd2871842842801, 64'd2871842842801,
    64'd2871842842801, 64'd26250887023729, 64'd26250887023729,
    64'd112434732901969, 64'd112434732901969, 64'd112434732901969,
    64'd178936222537081, 64'd178936222537081, 64'd696161110209049,
    64'd696161110209049, 64'd2854909648103881, 64'd6450045516630769,
    64'd6450045516630769, 64'd11641399247947921, 64'd11641399247947921,
    64'd190621428905186449, 64'd196640248121928601,
    64'd712624335095093521, 64'd1773855791877850321
  };

  // First primes, used as Euler test bases.
  localparam logic [7:0] BASE_TAB [BASE_N] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
    8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71,
    8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109,
    8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163,
    8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211,
    8'd223, 8'd227, 8'd229, 8'd233, 8'd239, 8'd241
  };

endpackage

// ===== design/pspt_div.sv =====
// ---------------------------------------------------------------------------
// pspt_div: bit-serial restoring divider
// Divides a 64-bit word by a 16-bit divisor, one quotient bit per cycle.
// The short mode handles a 16-bit dividend.
// ---------------------------------------------------------------------------
module pspt_div
  import pspt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               short_mode,
  input  logic [WORD_W-1:0]  dividend,
  input  logic [PRIME_W-1:0] divisor,
  output logic               done,
  output logic [WORD_W-1:0]  quo,
  output logic [PRIME_W-1:0] rem
);

  logic              busy;
  logic [6:0]        cnt;
  logic [WORD_W-1:0] num;
  logic [PRIME_W-1:0] dv;
  logic [PRIME_W:0]  trial;
  logic              ge;

  // Shift in the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem, num[WORD_W-1]};
    ge    = (trial >= {1'b0, dv});
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= short_mode ? 7'd16 : 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      num <= short_mode ? {dividend[PRIME_W-1:0], {(WORD_W-PRIME_W){1'b0}}}
                        : dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? PRIME_W'(trial - {1'b0, dv}) : trial[PRIME_W-1:0];
      num <= {num[WORD_W-2:0], ge};
    end
  end

  assign quo = num;

endmodule

// ===== design/pspt_mulmod.sv =====
// ---------------------------------------------------------------------------
// pspt_mulmod: bit-serial modular multiplier
// Computes a*b mod m by double-and-add over the 64 bits of b, one modular
// addition per cycle.
// ---------------------------------------------------------------------------
module pspt_mulmod
  import pspt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] m,
  output logic              done,
  output logic [WORD_W-1:0] res
);

  logic              busy;
  logic              add_ph;
  logic [5:0]        cnt;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] md;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W:0]   sum;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] sum_mod;

  // Modular add of r and the operand, both below m
  always_comb begin
    opnd    = add_ph ? x : r;
    sum     = {1'b0, r} + {1'b0, opnd};
    diff    = sum - {1'b0, md};
    sum_mod = diff[WORD_W] ? sum[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  // Step control: double, then add when the multiplier bit is set
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      add_ph <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        add_ph <= 1'b0;
        cnt    <= '0;
      end else if (busy) begin
        if (!add_ph && y[WORD_W-1]) begin
          add_ph <= 1'b1;
        end else begin
          add_ph <= 1'b0;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      x  <= a;
      y  <= b;
      md <= m;
      r  <= '0;
    end else if (busy) begin
      r <= sum_mod;
      if (add_ph || !y[WORD_W-1]) begin
        y <= {y[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign res = r;

endmodule

// ===== design/pseudosquare_primality_test_top.sv =====
// ---------------------------------------------------------------------------
// pseudosquare_primality_test_top: 64-bit pseudosquare primality tester
// Takes one candidate per item and returns a verdict: composite, prime, or
// probable prime that could not be proven.
// ---------------------------------------------------------------------------
// After reset the block counts primes by trial division to find the last
// trial prime and the bound prime (prime number TRIAL_PRIMES+1). It is not
// ready during that pass. One item is then in work at a time. Values below
// 2 and even values go straight to a verdict. Trial division runs over odd
// divisors up to the last trial prime on a bit-serial divider, so a prime
// below about 6e7 is proven by trial division alone. Larger candidates then
// take one full-width division, a table scan, and up to 53 modular
// exponentiations. Each exponentiation is up to 126 modular multiplications
// on the bit-serial multiplier, and the exponentiations dominate the work.
// ---------------------------------------------------------------------------
module pseudosquare_primality_test_top
  import pspt_pkg::*;
#(
  parameter int TRIAL_PRIMES       = 1000,
  parameter int PSEUDOSQUARE_COUNT = 52
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [1:0] verdict, [7:2] zero
);

  localparam int CNT_W = $clog2(TRIAL_PRIMES + 1);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(TRIAL_PRIMES - 1);
  localparam logic [CNT_W-1:0] BOUND_IDX = CNT_W'(TRIAL_PRIMES);
  localparam logic [IDX_W-1:0] PSC       = IDX_W'(PSEUDOSQUARE_COUNT);

  state_t state, state_next;

  logic [WORD_W-1:0]  n;
  logic [PRIME_W-1:0] d;
  logic [32:0]        dsq;
  logic [PRIME_W-1:0] c;
  logic [CNT_W-1:0]   cnt;
  logic [PRIME_W-1:0] plim;
  logic [PRIME_W-1:0] bdiv;
  logic [WORD_W-1:0]  nb;
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   lim;
  logic               phase;
  logic               saw;
  logic               minus0;
  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  base;
  logic [WORD_W-1:0]  e;
  verdict_t           verdict;
  logic               out_valid;
  verdict_t           out_data;

  // Shared unit handshakes
  logic               div_start;
  logic               div_short;
  logic [WORD_W-1:0]  div_dividend;
  logic [PRIME_W-1:0] div_divisor;
  logic               div_done;
  logic [WORD_W-1:0]  div_quo;
  logic [PRIME_W-1:0] div_rem;
  logic               mul_start;
  logic [WORD_W-1:0]  mul_a;
  logic [WORD_W-1:0]  mul_b;
  logic               mul_done;
  logic [WORD_W-1:0]  mul_res;

  // Decode helpers
  logic               accept;
  logic               boot_prime;
  logic               trial_end;
  logic               trial_sq;
  logic               scan_hit;
  logic [WORD_W-1:0]  n_m1;
  logic               is_one;
  logic               is_m1;
  logic               out_free;
  logic [32:0]        dsq_step;

  // Exponent check outcome
  logic               chk_end;
  verdict_t           chk_verdict;
  logic               chk_second;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign boot_prime = dsq > {17'd0, c};
  assign trial_end  = d > plim;
  assign trial_sq   = {31'd0, dsq} > n;
  assign scan_hit   = (k == PSC) || (PSQ_TAB[(k < PSC) ? k : '0] > nb);
  assign n_m1       = n - 64'd1;
  assign is_one     = (acc == 64'd1);
  assign is_m1      = (acc == n_m1);
  assign out_free   = !out_valid || m_axis_tready;
  assign dsq_step   = dsq + {15'd0, d, 2'b00} + 33'd4;

  // Decide what an Euler test result means
  always_comb begin
    chk_end     = 1'b0;
    chk_verdict = VERDICT_UNPROVEN;
    chk_second  = 1'b0;
    if (!phase) begin
      if (!is_one && !is_m1) begin
        chk_end     = 1'b1;
        chk_verdict = VERDICT_COMPOSITE;
      end else if (j == lim) begin
        chk_end = 1'b1;
        case (n[2:0])
          3'd3, 3'd7: chk_verdict = VERDICT_PRIME;
          3'd5: begin
            chk_verdict = (((j == '0) ? is_m1 : minus0)) ? VERDICT_PRIME
                                                          : VERDICT_UNPROVEN;
          end
          default: begin
            if (saw || is_m1) begin
              chk_verdict = VERDICT_PRIME;
            end else if (lim == PSC) begin
              chk_verdict = VERDICT_UNPROVEN;
            end else begin
              chk_end    = 1'b0;
              chk_second = 1'b1;
            end
          end
        endcase
      end
    end else begin
      if (is_m1) begin
        chk_end     = 1'b1;
        chk_verdict = VERDICT_PRIME;
      end else if (!is_one || j == PSC) begin
        chk_end     = 1'b1;
        chk_verdict = VERDICT_UNPROVEN;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_BOOT_CAND: begin
        if (boot_prime) begin
          if (cnt == BOUND_IDX) state_next = S_IDLE;
        end else begin
          state_next = S_BOOT_DIV;
        end
      end
      S_BOOT_DIV:  if (div_done) state_next = S_BOOT_CAND;
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tdata < 64'd2 || !s_axis_tdata[0]) state_next = S_DONE;
          else state_next = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (trial_end)     state_next = S_BOUND;
        else if (trial_sq) state_next = S_DONE;
        else               state_next = S_TRIAL_DIV;
      end
      S_TRIAL_DIV: begin
        if (div_done) state_next = (div_rem == '0) ? S_DONE : S_TRIAL;
      end
      S_BOUND:     if (div_done) state_next = S_SCAN;
      S_SCAN:      if (scan_hit) state_next = S_EXP_START;
      S_EXP_START: state_next = S_POW;
      S_POW: begin
        if (e == '0)  state_next = S_EXP_CHECK;
        else if (e[0]) state_next = S_MACC;
        else           state_next = S_MSQ;
      end
      S_MACC:      if (mul_done) state_next = S_MSQ;
      S_MSQ:       if (mul_done) state_next = S_POW;
      S_EXP_CHECK: state_next = chk_end ? S_DONE : S_EXP_START;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_BOOT_CAND;
    endcase
  end

  // Unit requests and handshake outputs
  always_comb begin
    div_start    = 1'b0;
    div_short    = 1'b0;
    div_dividend = n;
    div_divisor  = d;
    mul_start    = 1'b0;
    mul_a        = base;
    mul_b        = base;
    case (state)
      S_BOOT_CAND: begin
        div_start    = !boot_prime;
        div_short    = 1'b1;
        div_dividend = {48'd0, c};
      end
      S_TRIAL: begin
        div_start = !trial_sq || trial_end;
        if (trial_end) begin
          div_dividend = n_m1;
          div_divisor  = bdiv;
        end
      end
      S_POW: begin
        mul_start = (e != '0);
        if (e[0]) mul_a = acc;
      end
      S_MACC:  mul_start = mul_done;
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_data};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT_CAND;
      out_valid <= 1'b0;
      c         <= PRIME_W'(3);
      d         <= PRIME_W'(3);
      dsq       <= 33'd9;
      cnt       <= CNT_W'(1);
    end else begin
      state <= state_next;
      // Load the verdict into the output register, drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_data  <= verdict;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        // Count primes to find the last trial prime and the bound prime
        S_BOOT_CAND: begin
          if (boot_prime) begin
            if (cnt == LAST_IDX)  plim <= c;
            if (cnt == BOUND_IDX) bdiv <= c;
            cnt <= cnt + CNT_W'(1);
            c   <= c + PRIME_W'(2);
            d   <= PRIME_W'(3);
            dsq <= 33'd9;
          end
        end
        S_BOOT_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              c   <= c + PRIME_W'(2);
              d   <= PRIME_W'(3);
              dsq <= 33'd9;
            end else begin
              d   <= d + PRIME_W'(2);
              dsq <= dsq_step;
            end
          end
        end
        // Take an item and settle the trivial cases
        S_IDLE: begin
          if (accept) begin
            n   <= s_axis_tdata;
            d   <= PRIME_W'(3);
            dsq <= 33'd9;
            if (s_axis_tdata < 64'd2) begin
              verdict <= VERDICT_COMPOSITE;
            end else if (!s_axis_tdata[0]) begin
              verdict <= (s_axis_tdata == 64'd2) ? VERDICT_PRIME
                                                  : VERDICT_COMPOSITE;
            end
          end
        end
        S_TRIAL: begin
          if (!trial_end && trial_sq) verdict <= VERDICT_PRIME;
        end
        S_TRIAL_DIV: begin
          if (div_done) begin
            verdict <= VERDICT_COMPOSITE;
            d       <= d + PRIME_W'(2);
            dsq     <= dsq_step;
          end
        end
        S_BOUND: begin
          if (div_done) begin
            nb <= div_quo + 64'd1;
            k  <= '0;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            lim   <= k;
            j     <= '0;
            phase <= 1'b0;
            saw   <= 1'b0;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_EXP_START: begin
          acc  <= 64'd1;
          base <= {56'd0, BASE_TAB[j]};
          e    <= {1'b0, n[WORD_W-1:1]};
        end
        S_MACC: if (mul_done) acc <= mul_res;
        S_MSQ: begin
          if (mul_done) begin
            base <= mul_res;
            e    <= {1'b0, e[WORD_W-1:1]};
          end
        end
        S_EXP_CHECK: begin
          verdict <= chk_verdict;
          if (!phase) begin
            saw <= saw || is_m1;
            if (j == '0) minus0 <= is_m1;
          end
          if (chk_second) begin
            phase <= 1'b1;
            j     <= lim + IDX_W'(1);
          end else begin
            j <= j + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  pspt_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .short_mode (div_short),
    .dividend   (div_dividend),
    .divisor    (div_divisor),
    .done       (div_done),
    .quo        (div_quo),
    .rem        (div_rem)
  );

  pspt_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (n),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Check sequencing of the shared units
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MACC || state == S_MSQ))
    else $error("multiplier finished outside a multiply wait");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_BOOT_DIV || state == S_TRIAL_DIV || state == S_BOUND))
    else $error("divider finished outside a divide wait");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("ready stayed high after an item was taken");

  a_trial_odd: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIAL) |-> (d[0] && n[0]))
    else $error("trial division on an even divisor or candidate");

  a_out_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("verdict code out of range");

endmodule

// ===== tb/pseudosquare_primality_test_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pseudosquare_primality_test_top_test: self-checking bench for the tester
// Sends 64-bit candidates, predicts each verdict with a local model of the
// trial division, pseudosquare bound and Euler tests, and checks results in
// order under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module pseudosquare_primality_test_top_test;
  import pspt_pkg::*;

  localparam int NUM_TRIAL     = 1000;
  localparam int NUM_PSQ       = 52;
  localparam int WATCHDOG_LIMIT = 8_000_000;
  localparam int DRAIN_CYCLES  = 200;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  verdict_t    verdict_q[$];
  logic [63:0] cand_q[$];
  logic [63:0] small_primes [NUM_TRIAL+1];
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          mismatches;
  int          checked;
  int          sent;
  int          n_prime;
  int          n_unproven;
  int          quiet_cycles = 0;

  pseudosquare_primality_test_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [63:0] candidate
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [1:0] verdict, [7:2] zero
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Build the table of the first NUM_TRIAL+1 primes
  function automatic void build_primes();
    int cnt;
    int v;
    bit is_p;
    cnt = 0;
    v = 2;
    while (cnt <= NUM_TRIAL) begin
      is_p = 1'b1;
      for (int d = 2; d * d <= v; d++) begin
        if (v % d == 0) begin
          is_p = 1'b0;
          break;
        end
      end
      if (is_p) begin
        small_primes[cnt] = 64'(v);
        cnt++;
      end
      v++;
    end
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1 % m;
    b = base % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Expected verdict for one candidate
  function automatic verdict_t primality_verdict(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nb;
    logic [63:0] ex;
    logic [63:0] r;
    int          k;
    bit          saw_minus;
    saw_minus = 1'b0;
    if (n < 2) return VERDICT_COMPOSITE;
    if (!n[0]) return (n == 2) ? VERDICT_PRIME : VERDICT_COMPOSITE;
    for (int i = 0; i < NUM_TRIAL; i++) begin
      p = small_primes[i];
      if (p * p > n) return VERDICT_PRIME;
      if (n % p == 0) return VERDICT_COMPOSITE;
    end
    nb = (n - 1) / small_primes[NUM_TRIAL] + 1;
    for (k = 0; k < NUM_PSQ; k++)
      if (PSQ_TAB[k] > nb) break;
    ex = (n - 1) >> 1;
    for (int j = 0; j <= k; j++) begin
      r = pow_mod(small_primes[j], ex, n);
      if (r != 1 && r != n - 1) return VERDICT_COMPOSITE;
      if (r == n - 1) saw_minus = 1'b1;
    end
    if (n[2:0] == 3'd3 || n[2:0] == 3'd7) return VERDICT_PRIME;
    if (n[2:0] == 3'd5)
      return (pow_mod(2, ex, n) == n - 1) ? VERDICT_PRIME : VERDICT_UNPROVEN;
    if (saw_minus) return VERDICT_PRIME;
    for (int j = k + 1; j <= NUM_PSQ; j++) begin
      r = pow_mod(small_primes[j], ex, n);
      if (r == n - 1) return VERDICT_PRIME;
      if (r != 1) return VERDICT_UNPROVEN;
    end
    return VERDICT_UNPROVEN;
  endfunction

  // Offer one candidate; keep tvalid high until accepted
  task automatic send_candidate(logic [63:0] cand);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cand;
    do @(posedge clk); while (!s_axis_tready);
    verdict_q.push_back(primality_verdict(cand));
    cand_q.push_back(cand);
    sent++;
  endtask

  task automatic wait_all_verdicts();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Mostly cheap candidates, a share of full-width odd values
  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    int          sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 35) return v >> $urandom_range(40, 63);
    if (sel < 55) return v | 64'd1;
    if (sel < 75) return {$urandom_range(7919), 1'b1} * 64'($urandom_range(1, 7927));
    return v >> $urandom_range(0, 39);
  endfunction

  task automatic test_directed();
    logic [63:0] list[$];
    list = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd7919, 64'd7927,
             64'd62742241,            // 7921 squared, which is 89 to the fourth
             64'd62932489,            // 7933 squared
             64'd1000000007,          // residue 7
             64'd998244353,           // residue 1
             64'd3215031751,          // strong pseudoprime to small bases
             64'd2147483647,
             64'd2305843009213693951, // 2^61-1
             64'd18446744073709551557, // largest 64-bit prime, residue 5
             64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'h8000_0000_0000_0001, 64'd1773855791877850321};
    foreach (list[i]) send_candidate(list[i]);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // Hold off once until the block has drained
      if (i == count / 2) wait_all_verdicts();
      send_candidate(random_candidate());
    end
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Check each verdict against the oldest prediction
  always @(posedge clk) begin
    verdict_t    want;
    logic [63:0] cand;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0d", m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        cand = cand_q.pop_front();
        checked++;
        if (want == VERDICT_PRIME) n_prime++;
        if (want == VERDICT_UNPROVEN) n_unproven++;
        if (m_axis_tdata !== {6'd0, want}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("candidate %0d: expected %0d got %0d", cand, want, m_axis_tdata);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d verdicts outstanding", verdict_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    checked = 0;
    sent = 0;
    n_prime = 0;
    n_unproven = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 64'd0;
    build_primes();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(25, 0, 0);
    test_random(25, 64, 0);
    test_random(25, 0, 64);
    test_random(25, 38, 38);
    wait_all_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d candidates, checked %0d verdicts (%0d prime, %0d unproven)",
             sent, checked, n_prime, n_unproven);
    $display("idling phases: none, sender 64%%, receiver 64%%, both 38%%");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
